[rtl/rsdf_pkg.sv]
// shared types, codes and helpers for the relay shadow table with dirty flush
`timescale 1ns / 1ps

package rsdf_pkg;

  // sizes
  localparam int MODULE_COUNT_DEF = 16;
  localparam int MAX_MODULES      = 16;
  localparam int SLOT_W           = 4;
  localparam int WORD_W           = 16;
  localparam int ID_W             = 11;
  localparam int BYTE_W           = 8;
  localparam int LEN_W            = 4;
  localparam int STATUS_W         = 3;
  localparam int CFG_IDX_W        = 2;

  // reset values of the configuration registers
  localparam logic [ID_W-1:0] STATE_ID_MASK_RST  = 11'h7F0;
  localparam logic [ID_W-1:0] STATE_ID_MATCH_RST = 11'h000;
  localparam logic [ID_W-1:0] CONTROL_ID_RST     = 11'h000;
  localparam logic            BUS_PRESENT_RST    = 1'b1;

  // frame length of a relay state message
  localparam logic [LEN_W-1:0] STATE_LEN = 4'd2;

  // input actions
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_FLUSH = 2'd2;
  localparam logic [1:0] ACT_FRAME = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_BUS    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STATE_ID_MASK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STATE_ID_MATCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_ID     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BUS_PRESENT    = 2'd3;

  // work kind of an accepted item
  typedef enum logic [2:0] {
    OP_STATUS,
    OP_WRITE,
    OP_READ,
    OP_FRAME,
    OP_FLUSH
  } op_t;

  // control states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // index of the lowest set bit, zero when none
  function automatic logic [SLOT_W-1:0] first_one(input logic [MAX_MODULES-1:0] v);
    logic [SLOT_W-1:0] pos;
    pos = '0;
    for (int i = MAX_MODULES - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = SLOT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

[rtl/rsdf_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps

module rsdf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/relay_shadow_dirty_flush_top.sv]
// relay shadow table with dirty bitmap, flush sequencing and frame compare
// flow: an accepted item enters the exec state while its table word is read;
//   its result is registered into the output register once the output is free
// throughput: one item at a time, one table read per item or flushed frame; a
//   flush sends one frame per cycle unless stalled, paced by the table read port
// reset: synchronous active-low rst_n clears the control state, the dirty map,
//   the per-entry valid bits (table reads as zero); config registers get reset values
`timescale 1ns / 1ps

module relay_shadow_dirty_flush_top #(
  parameter int MODULE_COUNT = rsdf_pkg::MODULE_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // item input
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_action,
  input  logic [rsdf_pkg::BYTE_W-1:0]        in_module_addr,
  input  logic [rsdf_pkg::BYTE_W-1:0]        in_relay_index,
  input  logic                               in_relay_value,
  input  logic [rsdf_pkg::ID_W-1:0]          in_rx_id,
  input  logic                               in_rx_extended,
  input  logic [rsdf_pkg::LEN_W-1:0]         in_rx_length,
  input  logic [rsdf_pkg::WORD_W-1:0]        in_rx_word,
  // result output
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_tx_valid,
  output logic [rsdf_pkg::ID_W-1:0]          out_tx_id,
  output logic [rsdf_pkg::WORD_W-1:0]        out_tx_word,
  output logic                               out_read_bit,
  output logic [rsdf_pkg::STATUS_W-1:0]      out_status,
  output logic                               out_last,
  // configuration writes
  input  logic                               cfg_wr_en,
  input  logic [rsdf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rsdf_pkg::ID_W-1:0]          cfg_data
);

  localparam int ADDR_W = (MODULE_COUNT > 1) ? $clog2(MODULE_COUNT) : 1;
  localparam int IDX_W  = $clog2(rsdf_pkg::WORD_W);

  // config registers
  logic [rsdf_pkg::ID_W-1:0] id_mask_r;
  logic [rsdf_pkg::ID_W-1:0] id_match_r;
  logic [rsdf_pkg::ID_W-1:0] id_base_r;
  logic                      bus_r;

  // control and item registers
  rsdf_pkg::state_t state_r, state_nxt;
  rsdf_pkg::op_t    op_r, acc_op;
  logic [rsdf_pkg::STATUS_W-1:0] status_r, acc_status;
  logic [ADDR_W-1:0]             addr_r, acc_addr, next_addr;
  logic [IDX_W-1:0]              idx_r;
  logic                          val_r;
  logic [rsdf_pkg::WORD_W-1:0]   rx_word_r;
  logic [MODULE_COUNT-1:0]       dirty_r;
  logic [MODULE_COUNT-1:0]       scan_r, scan_rest;
  logic [MODULE_COUNT-1:0]       vld_r;

  // output register
  logic                          out_valid_r;
  logic                          out_tx_valid_r;
  logic [rsdf_pkg::ID_W-1:0]     out_tx_id_r;
  logic [rsdf_pkg::WORD_W-1:0]   out_tx_word_r;
  logic                          out_read_bit_r;
  logic [rsdf_pkg::STATUS_W-1:0] out_status_r;
  logic                          out_last_r;

  // result of the executing step
  logic                          res_tx_valid;
  logic [rsdf_pkg::WORD_W-1:0]   res_tx_word;
  logic                          res_read_bit;
  logic [rsdf_pkg::STATUS_W-1:0] res_status;
  logic                          res_last;
  logic                          res_more;

  // table memory
  logic                          mem_we;
  logic [ADDR_W-1:0]             mem_raddr;
  logic [rsdf_pkg::WORD_W-1:0]   mem_rdata, mem_wdata, cur_word;
  logic                          mark_dirty;

  logic accept, out_free, done;
  logic addr_bad, idx_bad, rx_bad;
  logic [rsdf_pkg::SLOT_W-1:0] dirty_first, rest_first;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign done     = (state_r == rsdf_pkg::S_EXEC) && out_free;

  rsdf_ram #(
    .WIDTH (rsdf_pkg::WORD_W),
    .DEPTH (MODULE_COUNT),
    .AW    (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr_r),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // entries never written read as zero
  assign cur_word = vld_r[addr_r] ? mem_rdata : '0;

  // decode of an incoming item
  assign addr_bad = in_module_addr >= rsdf_pkg::BYTE_W'(MODULE_COUNT);
  assign idx_bad  = in_relay_index >= rsdf_pkg::BYTE_W'(rsdf_pkg::WORD_W);
  assign rx_bad   = in_rx_extended
                 || ((in_rx_id & id_mask_r) != id_match_r)
                 || (in_rx_length != rsdf_pkg::STATE_LEN)
                 || ({4'b0, in_rx_id[3:0]} >= rsdf_pkg::BYTE_W'(MODULE_COUNT));
  assign dirty_first = rsdf_pkg::first_one(rsdf_pkg::MAX_MODULES'(dirty_r));

  always_comb begin
    acc_op     = rsdf_pkg::OP_STATUS;
    acc_status = rsdf_pkg::ST_OK;
    acc_addr   = in_module_addr[ADDR_W-1:0];
    unique case (in_action) inside
      rsdf_pkg::ACT_WRITE, rsdf_pkg::ACT_READ: begin
        if (addr_bad) begin
          acc_status = rsdf_pkg::ST_BAD_ADDR;
        end else if (idx_bad) begin
          acc_status = rsdf_pkg::ST_BAD_INDEX;
        end else begin
          acc_op = (in_action == rsdf_pkg::ACT_WRITE) ? rsdf_pkg::OP_WRITE
                                                      : rsdf_pkg::OP_READ;
        end
      end
      rsdf_pkg::ACT_FLUSH: begin
        acc_addr = dirty_first[ADDR_W-1:0];
        if (dirty_r == '0) begin
          acc_status = rsdf_pkg::ST_OK;
        end else if (!bus_r) begin
          acc_status = rsdf_pkg::ST_NO_BUS;
        end else begin
          acc_op = rsdf_pkg::OP_FLUSH;
        end
      end
      rsdf_pkg::ACT_FRAME: begin
        acc_addr = in_rx_id[ADDR_W-1:0];
        if (rx_bad) begin
          acc_status = rsdf_pkg::ST_IGNORED;
        end else begin
          acc_op = rsdf_pkg::OP_FRAME;
        end
      end
    endcase
  end

  // remaining dirty modules of a flush
  assign scan_rest  = scan_r & ~(MODULE_COUNT'(1) << addr_r);
  assign rest_first = rsdf_pkg::first_one(rsdf_pkg::MAX_MODULES'(scan_rest));
  assign next_addr  = rest_first[ADDR_W-1:0];

  // result and write-back of the executing step
  always_comb begin
    res_tx_valid = 1'b0;
    res_tx_word  = '0;
    res_read_bit = 1'b0;
    res_status   = rsdf_pkg::ST_OK;
    res_last     = 1'b1;
    res_more     = 1'b0;
    mem_wdata    = cur_word;
    mark_dirty   = 1'b0;
    case (op_r)
      rsdf_pkg::OP_STATUS: begin
        res_status = status_r;
      end
      rsdf_pkg::OP_READ: begin
        res_read_bit = cur_word[idx_r];
      end
      rsdf_pkg::OP_WRITE: begin
        mem_wdata[idx_r] = val_r;
        mark_dirty       = cur_word[idx_r] != val_r;
      end
      rsdf_pkg::OP_FRAME: begin
        if (cur_word == rx_word_r) begin
          res_status = rsdf_pkg::ST_OK;
        end else if (!bus_r) begin
          res_status = rsdf_pkg::ST_NO_BUS;
        end else begin
          res_tx_valid = 1'b1;
          res_tx_word  = cur_word;
        end
      end
      rsdf_pkg::OP_FLUSH: begin
        res_tx_valid = 1'b1;
        res_tx_word  = cur_word;
        res_more     = scan_rest != '0;
        res_last     = !res_more;
      end
      default: begin
        res_status = status_r;
      end
    endcase
  end

  assign mem_we = done && mark_dirty;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rsdf_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = rsdf_pkg::S_EXEC;
        end
      end
      rsdf_pkg::S_EXEC: begin
        if (done && !res_more) begin
          state_nxt = rsdf_pkg::S_IDLE;
        end
      end
    endcase
  end

  // state outputs: handshake and table read address
  always_comb begin
    in_ready  = 1'b0;
    mem_raddr = addr_r;
    unique case (state_r)
      rsdf_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        mem_raddr = acc_addr;
      end
      rsdf_pkg::S_EXEC: begin
        if (done && res_more) begin
          mem_raddr = next_addr;
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsdf_pkg::S_IDLE;
      op_r        <= rsdf_pkg::OP_STATUS;
      dirty_r     <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        op_r <= acc_op;
      end
      // flush takes the whole map at once
      if (accept && in_action == rsdf_pkg::ACT_FLUSH) begin
        dirty_r <= '0;
      end else if (mem_we) begin
        dirty_r[addr_r] <= 1'b1;
      end
      if (mem_we) begin
        vld_r[addr_r] <= 1'b1;
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item payload registers
  always_ff @(posedge clk) begin
    addr_r <= mem_raddr;
    if (accept) begin
      status_r  <= acc_status;
      idx_r     <= in_relay_index[IDX_W-1:0];
      val_r     <= in_relay_value;
      rx_word_r <= in_rx_word;
      scan_r    <= dirty_r;
    end else if (done) begin
      scan_r <= scan_rest;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (done) begin
      out_tx_valid_r <= res_tx_valid;
      out_tx_id_r    <= res_tx_valid ? (id_base_r | rsdf_pkg::ID_W'(addr_r)) : '0;
      out_tx_word_r  <= res_tx_word;
      out_read_bit_r <= res_read_bit;
      out_status_r   <= res_status;
      out_last_r     <= res_last;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_mask_r  <= rsdf_pkg::STATE_ID_MASK_RST;
      id_match_r <= rsdf_pkg::STATE_ID_MATCH_RST;
      id_base_r  <= rsdf_pkg::CONTROL_ID_RST;
      bus_r      <= rsdf_pkg::BUS_PRESENT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rsdf_pkg::CFG_STATE_ID_MASK:  id_mask_r  <= cfg_data;
        rsdf_pkg::CFG_STATE_ID_MATCH: id_match_r <= cfg_data;
        rsdf_pkg::CFG_CONTROL_ID:     id_base_r  <= cfg_data;
        rsdf_pkg::CFG_BUS_PRESENT:    bus_r      <= cfg_data[0];
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_tx_valid = out_tx_valid_r;
  assign out_tx_id    = out_tx_id_r;
  assign out_tx_word  = out_tx_word_r;
  assign out_read_bit = out_read_bit_r;
  assign out_status   = out_status_r;
  assign out_last     = out_last_r;

endmodule

[rtl/rsdf_checker.sv]
// port-level checks for the relay shadow table, bound to the top level
`timescale 1ns / 1ps

module rsdf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_tx_valid,
  input logic [rsdf_pkg::ID_W-1:0]     out_tx_id,
  input logic [rsdf_pkg::WORD_W-1:0]   out_tx_word,
  input logic                          out_read_bit,
  input logic [rsdf_pkg::STATUS_W-1:0] out_status,
  input logic                          out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tx_word) && $stable(out_status)
      && $stable(out_last))
    else $error("stalled result changed");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while another is in work");

  // a frame always carries ok status and no read bit
  a_frame_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_valid |-> out_status == rsdf_pkg::ST_OK && !out_read_bit)
    else $error("frame with error status");

  // no frame means zero id and word
  a_no_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_valid |-> out_tx_id == '0 && out_tx_word == '0)
    else $error("frame fields set without a frame");

  // an error result closes its item
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != rsdf_pkg::ST_OK |-> out_last && !out_tx_valid)
    else $error("error result not final");

endmodule

bind relay_shadow_dirty_flush_top rsdf_checker u_rsdf_checker (.*);

[tb/sv/tb_rsdf_check_pkg.sv]
// item and result types plus the relay table scoreboard for the relay shadow testbench
`timescale 1ns / 1ps

package tb_rsdf_check_pkg;

  import rsdf_pkg::*;

  // one input item as driven on the in_ ports
  typedef struct packed {
    logic [1:0]        action;
    logic [BYTE_W-1:0] module_addr;
    logic [BYTE_W-1:0] relay_index;
    logic              relay_value;
    logic [ID_W-1:0]   rx_id;
    logic              rx_extended;
    logic [LEN_W-1:0]  rx_length;
    logic [WORD_W-1:0] rx_word;
  } relay_item_t;

  // one result as seen on the out_ ports
  typedef struct packed {
    logic                tx_valid;
    logic [ID_W-1:0]     tx_id;
    logic [WORD_W-1:0]   tx_word;
    logic                read_bit;
    logic [STATUS_W-1:0] status;
    logic                last;
  } relay_result_t;

  class relay_shadow_checker;
    logic [WORD_W-1:0]      relay_words [MODULE_COUNT_DEF];
    logic [MAX_MODULES-1:0] dirty_map;
    logic [ID_W-1:0]        id_mask;
    logic [ID_W-1:0]        id_match;
    logic [ID_W-1:0]        ctrl_base;
    logic                   bus_on;
    relay_result_t          pending_results [$];
    int                     errors;

    function new();
      foreach (relay_words[i]) relay_words[i] = '0;
      dirty_map = '0;
      id_mask   = STATE_ID_MASK_RST;
      id_match  = STATE_ID_MATCH_RST;
      ctrl_base = CONTROL_ID_RST;
      bus_on    = BUS_PRESENT_RST;
      errors    = 0;
    endfunction

    // mirror of a register write
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] data);
      case (idx)
        CFG_STATE_ID_MASK:  id_mask = data;
        CFG_STATE_ID_MATCH: id_match = data;
        CFG_CONTROL_ID:     ctrl_base = data;
        CFG_BUS_PRESENT:    bus_on = data[0];
        default: ;
      endcase
    endfunction

    // queue one expected result, frame fields zero unless a frame is sent
    function void add_result(logic txv, logic [SLOT_W-1:0] slot, logic [WORD_W-1:0] word,
                             logic rd_bit, logic [STATUS_W-1:0] st);
      relay_result_t r;
      r.tx_valid = txv;
      r.tx_id    = txv ? (ctrl_base | ID_W'(slot)) : '0;
      r.tx_word  = txv ? word : '0;
      r.read_bit = rd_bit;
      r.status   = st;
      r.last     = 1'b0;
      pending_results.push_back(r);
    endfunction

    // predict the results of one accepted item and update the shadow table
    function void note_item(relay_item_t it);
      logic [SLOT_W-1:0]      slot;
      logic [3:0]             pin;
      logic [MAX_MODULES-1:0] flushed;
      relay_result_t          tail;
      slot = it.module_addr[SLOT_W-1:0];
      pin  = it.relay_index[3:0];
      case (it.action)
        ACT_WRITE, ACT_READ: begin
          if (it.module_addr >= MODULE_COUNT_DEF) begin
            add_result(1'b0, '0, '0, 1'b0, ST_BAD_ADDR);
          end else if (it.relay_index >= WORD_W) begin
            add_result(1'b0, '0, '0, 1'b0, ST_BAD_INDEX);
          end else if (it.action == ACT_READ) begin
            add_result(1'b0, '0, '0, relay_words[slot][pin], ST_OK);
          end else begin
            // only a real change marks the module dirty
            if (relay_words[slot][pin] != it.relay_value) begin
              relay_words[slot][pin] = it.relay_value;
              dirty_map[slot] = 1'b1;
            end
            add_result(1'b0, '0, '0, 1'b0, ST_OK);
          end
        end
        ACT_FLUSH: begin
          flushed = dirty_map;
          dirty_map = '0;
          if (flushed == '0) begin
            add_result(1'b0, '0, '0, 1'b0, ST_OK);
          end else if (!bus_on) begin
            add_result(1'b0, '0, '0, 1'b0, ST_NO_BUS);
          end else begin
            for (int a = 0; a < MODULE_COUNT_DEF; a++) begin
              if (flushed[a]) add_result(1'b1, SLOT_W'(a), relay_words[a], 1'b0, ST_OK);
            end
          end
        end
        default: begin
          // received frame: must be a standard state message of length two
          slot = it.rx_id[SLOT_W-1:0];
          if (it.rx_extended || ((it.rx_id & id_mask) != id_match) ||
              (it.rx_length != STATE_LEN) || (slot >= MODULE_COUNT_DEF)) begin
            add_result(1'b0, '0, '0, 1'b0, ST_IGNORED);
          end else if (relay_words[slot] == it.rx_word) begin
            add_result(1'b0, '0, '0, 1'b0, ST_OK);
          end else if (!bus_on) begin
            add_result(1'b0, '0, '0, 1'b0, ST_NO_BUS);
          end else begin
            add_result(1'b1, slot, relay_words[slot], 1'b0, ST_OK);
          end
        end
      endcase
      // flag the final result of this item
      tail = pending_results.pop_back();
      tail.last = 1'b1;
      pending_results.push_back(tail);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(relay_result_t got);
      relay_result_t exp;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 200)
          $display("%0t: result with none expected, actual tx_valid=%0b tx_id=%h tx_word=%h",
                   $time, got.tx_valid, got.tx_id, got.tx_word,
                   " read_bit=%0b status=%0d last=%0b", got.read_bit, got.status, got.last);
      end else begin
        exp = pending_results.pop_front();
        if (got.tx_valid !== exp.tx_valid || got.tx_id !== exp.tx_id ||
            got.tx_word !== exp.tx_word || got.read_bit !== exp.read_bit ||
            got.status !== exp.status || got.last !== exp.last) begin
          errors++;
          if (errors <= 200)
            $display("%0t: result mismatch, expected tx_valid=%0b tx_id=%h tx_word=%h",
                     $time, exp.tx_valid, exp.tx_id, exp.tx_word,
                     " read_bit=%0b status=%0d last=%0b", exp.read_bit, exp.status, exp.last,
                     ", actual tx_valid=%0b tx_id=%h tx_word=%h", got.tx_valid, got.tx_id,
                     got.tx_word, " read_bit=%0b status=%0d last=%0b", got.read_bit,
                     got.status, got.last);
        end
      end
    endfunction
  endclass

endpackage

[tb/sv/tb_relay_shadow_dirty_flush_top.sv]
// testbench top for the relay shadow table with dirty flush
`timescale 1ns / 1ps

module tb_relay_shadow_dirty_flush_top;

  import rsdf_pkg::*;
  import tb_rsdf_check_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_action = ACT_WRITE;
  logic [BYTE_W-1:0]    in_module_addr = '0;
  logic [BYTE_W-1:0]    in_relay_index = '0;
  logic                 in_relay_value = 1'b0;
  logic [ID_W-1:0]      in_rx_id = '0;
  logic                 in_rx_extended = 1'b0;
  logic [LEN_W-1:0]     in_rx_length = '0;
  logic [WORD_W-1:0]    in_rx_word = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_tx_valid;
  logic [ID_W-1:0]      out_tx_id;
  logic [WORD_W-1:0]    out_tx_word;
  logic                 out_read_bit;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_last;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_STATE_ID_MASK;
  logic [ID_W-1:0]      cfg_data = '0;

  int send_idle_pct = 6;
  int recv_idle_pct = 65;
  int cycle_count = 0;

  relay_shadow_checker shadow_chk;

  relay_shadow_dirty_flush_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_module_addr (in_module_addr),
    .in_relay_index (in_relay_index),
    .in_relay_value (in_relay_value),
    .in_rx_id       (in_rx_id),
    .in_rx_extended (in_rx_extended),
    .in_rx_length   (in_rx_length),
    .in_rx_word     (in_rx_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tx_valid   (out_tx_valid),
    .out_tx_id      (out_tx_id),
    .out_tx_word    (out_tx_word),
    .out_read_bit   (out_read_bit),
    .out_status     (out_status),
    .out_last       (out_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // clock
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[relay_shadow_dirty_flush_top] ERROR");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result monitor
  always @(posedge clk) begin : result_mon
    relay_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.tx_valid = out_tx_valid;
      got.tx_id    = out_tx_id;
      got.tx_word  = out_tx_word;
      got.read_bit = out_read_bit;
      got.status   = out_status;
      got.last     = out_last;
      shadow_chk.check_result(got);
    end
  end

  // host write or read item
  function automatic relay_item_t host_item(logic [1:0] act, logic [BYTE_W-1:0] addr,
                                            logic [BYTE_W-1:0] idx, logic val);
    relay_item_t it;
    it = '0;
    it.action      = act;
    it.module_addr = addr;
    it.relay_index = idx;
    it.relay_value = val;
    return it;
  endfunction

  // received bus frame item
  function automatic relay_item_t bus_frame(logic [ID_W-1:0] id, logic ext,
                                            logic [LEN_W-1:0] len, logic [WORD_W-1:0] word);
    relay_item_t it;
    it = '0;
    it.action      = ACT_FRAME;
    it.rx_id       = id;
    it.rx_extended = ext;
    it.rx_length   = len;
    it.rx_word     = word;
    return it;
  endfunction

  // random item, mostly well formed with some bad addresses, bad indexes and noise frames
  function automatic relay_item_t make_item();
    relay_item_t       it;
    int                pick;
    logic [WORD_W-1:0] shadow;
    it.module_addr = BYTE_W'($urandom_range(255));
    it.relay_index = BYTE_W'($urandom_range(255));
    it.relay_value = 1'($urandom_range(1));
    it.rx_id       = ID_W'($urandom_range(2047));
    it.rx_extended = 1'($urandom_range(1));
    it.rx_length   = LEN_W'($urandom_range(15));
    it.rx_word     = WORD_W'($urandom_range(65535));
    pick = $urandom_range(99);
    if (pick < 45) it.action = ACT_WRITE;
    else if (pick < 60) it.action = ACT_READ;
    else if (pick < 72) it.action = ACT_FLUSH;
    else it.action = ACT_FRAME;
    if (it.action == ACT_WRITE || it.action == ACT_READ) begin
      if ($urandom_range(9) != 0) it.module_addr = BYTE_W'($urandom_range(MODULE_COUNT_DEF - 1));
      if ($urandom_range(9) != 0) it.relay_index = BYTE_W'($urandom_range(WORD_W - 1));
    end else if (it.action == ACT_FRAME && $urandom_range(3) != 0) begin
      // state message that passes the id filter
      it.rx_id = (shadow_chk.id_match & shadow_chk.id_mask) |
                 (ID_W'($urandom) & ~shadow_chk.id_mask);
      it.rx_extended = 1'b0;
      it.rx_length   = STATE_LEN;
      shadow = shadow_chk.relay_words[it.rx_id[SLOT_W-1:0]];
      case ($urandom_range(3))
        0, 1: it.rx_word = shadow;
        2: it.rx_word = shadow ^ (WORD_W'(1) << $urandom_range(WORD_W - 1));
        default: ;
      endcase
    end
    return it;
  endfunction

  // offer one item, with a random gap first, and wait for the handshake
  task automatic send_item(relay_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= it.action;
    in_module_addr <= it.module_addr;
    in_relay_index <= it.relay_index;
    in_relay_value <= it.relay_value;
    in_rx_id       <= it.rx_id;
    in_rx_extended <= it.rx_extended;
    in_rx_length   <= it.rx_length;
    in_rx_word     <= it.rx_word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shadow_chk.note_item(it);
  endtask

  // stop sending and wait until every expected result has come
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    while (shadow_chk.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one register write, write enable left high for the next one
  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    shadow_chk.set_reg(idx, data);
  endtask

  // program the full register set
  task automatic program_regs(logic [ID_W-1:0] mask, logic [ID_W-1:0] match,
                              logic [ID_W-1:0] base, logic bus);
    put_reg(CFG_STATE_ID_MASK, mask);
    put_reg(CFG_STATE_ID_MATCH, match);
    put_reg(CFG_CONTROL_ID, base);
    put_reg(CFG_BUS_PRESENT, {{(ID_W - 1){1'b0}}, bus});
    cfg_wr_en <= 1'b0;
  endtask

  // main sequence
  initial begin
    shadow_chk = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items under reset settings
    send_item(host_item(ACT_WRITE, 8'd0, 8'd0, 1'b1));
    send_item(host_item(ACT_WRITE, 8'd15, 8'd15, 1'b1));
    send_item(host_item(ACT_WRITE, 8'd15, 8'd15, 1'b1));   // no change, does not mark dirty
    send_item(host_item(ACT_WRITE, 8'd16, 8'd0, 1'b1));    // bad address
    send_item(host_item(ACT_WRITE, 8'd255, 8'd255, 1'b1)); // address checked first
    send_item(host_item(ACT_WRITE, 8'd3, 8'd16, 1'b1));    // bad relay index
    send_item(host_item(ACT_READ, 8'd0, 8'd0, 1'b0));
    send_item(host_item(ACT_READ, 8'd15, 8'd255, 1'b0));
    send_item(host_item(ACT_READ, 8'd200, 8'd5, 1'b0));
    send_item(host_item(ACT_FLUSH, 8'd0, 8'd0, 1'b0));     // two dirty modules
    send_item(host_item(ACT_FLUSH, 8'd0, 8'd0, 1'b0));     // nothing dirty
    send_item(bus_frame(11'h005, 1'b0, 4'd2, 16'h0000));   // equal to shadow
    send_item(bus_frame(11'h000, 1'b0, 4'd2, 16'hFFFF));   // differs, resend
    send_item(bus_frame(11'h000, 1'b1, 4'd2, 16'hFFFF));   // extended id
    send_item(bus_frame(11'h7FF, 1'b0, 4'd2, 16'hFFFF));   // id filter miss
    send_item(bus_frame(11'h000, 1'b0, 4'd8, 16'hFFFF));   // wrong length
    send_item(bus_frame(11'h000, 1'b0, 4'd0, 16'hFFFF));
    send_item(host_item(ACT_WRITE, 8'd0, 8'd0, 1'b0));
    send_item(host_item(ACT_WRITE, 8'd7, 8'd8, 1'b1));

    // directed items without a transmitter
    wait_for_quiet();
    program_regs(11'h000, 11'h000, 11'h7F0, 1'b0);
    send_item(host_item(ACT_FLUSH, 8'd0, 8'd0, 1'b0));     // dirty but no bus
    send_item(host_item(ACT_FLUSH, 8'd0, 8'd0, 1'b0));
    send_item(bus_frame(11'h7F7, 1'b0, 4'd2, 16'h1234));   // differs, no bus
    send_item(bus_frame(11'h7F7, 1'b0, 4'd2, 16'h0100));
    send_item(host_item(ACT_WRITE, 8'd1, 8'd5, 1'b1));
    send_item(host_item(ACT_FLUSH, 8'd0, 8'd0, 1'b0));

    // random phases, each under its own register set
    for (int ph = 0; ph < 6; ph++) begin
      wait_for_quiet();
      case (ph)
        0: program_regs(11'h7F0, 11'h120, 11'h7FF, 1'b1);
        1: program_regs(11'h7FF, 11'h003, 11'h000, 1'b1);
        2: program_regs(11'h000, 11'h000, 11'h2A0, 1'b0);
        3: program_regs(11'h00F, 11'h005, 11'h555, 1'b1);
        4: program_regs(11'h70F, 11'h70A, 11'h0F0, 1'b1);
        default: program_regs(11'h7FF, 11'h7FF, 11'h7F0, 1'b1);
      endcase
      send_idle_pct = (ph < 2) ? 6 : (ph < 4) ? 65 : 0;
      recv_idle_pct = (ph < 2) ? 65 : (ph < 4) ? 6 : 0;
      repeat (72) send_item(make_item());
    end

    wait_for_quiet();
    repeat (8) @(posedge clk);
    if (shadow_chk.errors == 0) begin
      $display("[relay_shadow_dirty_flush_top] OK");
    end else begin
      $display("[relay_shadow_dirty_flush_top] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rsdf_pkg.sv
rtl/rsdf_ram.sv
rtl/relay_shadow_dirty_flush_top.sv
rtl/rsdf_checker.sv
tb/sv/tb_rsdf_check_pkg.sv
tb/sv/tb_relay_shadow_dirty_flush_top.sv
